@@ sv/swa_pkg.sv @@
// shared types, codes and helpers for the serpentine window accumulator
`timescale 1ns / 1ps

package swa_pkg;

  localparam int CfgIdxW = 3;
  localparam int CoordW  = 9;
  localparam int AreaW   = 2 * CoordW;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_LEFT    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_TOP     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_COLUMNS = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_ROWS    = 3'd5;

  localparam logic [1:0] CMD_ACCUMULATE = 2'd0;
  localparam logic [1:0] CMD_READ       = 2'd1;
  localparam logic [1:0] CMD_RESTART    = 2'd2;

  typedef struct packed {
    logic [CoordW-1:0] image_width;
    logic [CoordW-1:0] image_height;
    logic [CoordW-1:0] window_left;
    logic [CoordW-1:0] window_top;
    logic [CoordW-1:0] window_columns;
    logic [CoordW-1:0] window_rows;
  } cfg_t;

  typedef struct packed {
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] x1;
    logic [CoordW-1:0] y0;
    logic [CoordW-1:0] y1;
    logic              empty;
    logic [AreaW-1:0]  area;
  } win_t;

  typedef struct packed {
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] next_col;
    logic [CoordW-1:0] next_row;
    logic              last;
  } scan_t;

  typedef struct packed {
    logic [31:0] red;
    logic [31:0] green;
    logic [31:0] blue;
    logic [15:0] count;
  } pix_entry_t;

  function automatic logic [31:0] sat_add32(logic [31:0] a, logic [15:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {17'd0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

@@ sv/serpentine_window_accumulator_unit.sv @@
// top level of the serpentine window accumulator with its pixel memory
`timescale 1ns / 1ps

// a request is registered into stage one at accept, and its result, strobed by result_valid_o,
//   is then registered from stage one into the result register
// requests: busy holds off a new request until the write-back of the last one is done, due to the
//   single read-modify-write of the pixel memory (read at accept, write back in the next cycle)
// reset: control clears at once, then a clearing pass zeroes all MAX_WIDTH*MAX_HEIGHT memory
//   entries, one entry a cycle, with busy high; config writes are taken anyway
// the receiver cannot stall: every result is presented for exactly one cycle
module serpentine_window_accumulator_unit import swa_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          command_i,
  input  logic [15:0]         red_in_i,
  input  logic [15:0]         green_in_i,
  input  logic [15:0]         blue_in_i,
  input  logic [15:0]         read_address_i,
  // config write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CoordW-1:0]   cfg_data_i,
  // result channel
  output logic                result_valid_o,
  output logic                accepted_o,
  output logic [15:0]         pixel_address_o,
  output logic [31:0]         red_sum_o,
  output logic [31:0]         green_sum_o,
  output logic [31:0]         blue_sum_o,
  output logic [15:0]         sample_count_o,
  output logic                pass_done_o
);

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int LinW  = AreaW + 1;

  // configuration registers
  cfg_t cfg_q, cfg_d;

  // scan position
  logic [CoordW-1:0] scan_col_q, scan_col_d, scan_row_q, scan_row_d;

  // clearing pass
  logic          clearing_q, clearing_d;
  logic [AW-1:0] clr_q, clr_d;

  // stage one: memory read in flight
  logic          s1_valid_q, s1_valid_d;
  logic [1:0]    s1_cmd_q, s1_cmd_d;
  logic          s1_ok_q, s1_ok_d;
  logic          s1_last_q, s1_last_d;
  logic [AW-1:0] s1_addr_q, s1_addr_d;
  logic [15:0]   s1_paddr_q, s1_paddr_d;
  logic [15:0]   s1_red_q, s1_red_d, s1_green_q, s1_green_d, s1_blue_q, s1_blue_d;

  // result register
  logic          result_valid_q;
  pix_entry_t    out_pix_q, out_pix_d;
  logic          out_ok_q, out_ok_d, out_last_q, out_last_d;
  logic [15:0]   out_paddr_q, out_paddr_d;

  // pixel memory
  pix_entry_t    store_q [Depth];
  pix_entry_t    rdata_q;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  pix_entry_t    mem_wdata, updated;

  win_t          win;
  scan_t         scan;
  logic          accept;
  logic [AreaW-1:0] row_prod;
  logic [LinW-1:0]  lin;
  logic [AW-1:0]    acc_addr;
  logic             read_ok;

  swa_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_scan (
    .cfg_i     (cfg_q),
    .scan_col_i(scan_col_q),
    .scan_row_i(scan_row_q),
    .win_o     (win),
    .scan_o    (scan)
  );

  // the pending write-back and the clearing pass both block new requests,
  // so a read never races a write to the same entry
  assign busy        = clearing_q | s1_valid_q;
  assign accept      = start & ~busy;
  assign cfg_ready_o = 1'b1;

  // config writes, indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_IMAGE_WIDTH:    cfg_d.image_width    = cfg_data_i;
        CFG_IMAGE_HEIGHT:   cfg_d.image_height   = cfg_data_i;
        CFG_WINDOW_LEFT:    cfg_d.window_left    = cfg_data_i;
        CFG_WINDOW_TOP:     cfg_d.window_top     = cfg_data_i;
        CFG_WINDOW_COLUMNS: cfg_d.window_columns = cfg_data_i;
        CFG_WINDOW_ROWS:    cfg_d.window_rows    = cfg_data_i;
        default: ;
      endcase
    end
  end

  // linear address of the current scan pixel, clamped to the memory
  always_comb begin
    row_prod = scan.row * win.w;
    lin      = {1'b0, row_prod} + LinW'(scan.col);
    acc_addr = (32'(lin) >= 32'(Depth)) ? AW'(Depth - 1) : AW'(lin);
    read_ok  = ({2'b00, read_address_i} < win.area) && (32'(read_address_i) < 32'(Depth));
  end

  // request decode, scan update and memory read issue
  always_comb begin
    scan_col_d = scan_col_q;
    scan_row_d = scan_row_q;
    s1_valid_d = accept;
    s1_cmd_d   = s1_cmd_q;
    s1_ok_d    = s1_ok_q;
    s1_last_d  = s1_last_q;
    s1_addr_d  = s1_addr_q;
    s1_paddr_d = s1_paddr_q;
    s1_red_d   = s1_red_q;
    s1_green_d = s1_green_q;
    s1_blue_d  = s1_blue_q;
    mem_re     = 1'b0;
    mem_raddr  = acc_addr;
    if (accept) begin
      s1_cmd_d   = command_i;
      s1_ok_d    = 1'b0;
      s1_last_d  = 1'b0;
      s1_paddr_d = '0;
      s1_red_d   = red_in_i;
      s1_green_d = green_in_i;
      s1_blue_d  = blue_in_i;
      s1_addr_d  = acc_addr;
      unique case (command_i)
        CMD_ACCUMULATE: begin
          if (!win.empty) begin
            s1_ok_d    = 1'b1;
            s1_last_d  = scan.last;
            s1_paddr_d = 16'(acc_addr);
            mem_re     = 1'b1;
            scan_col_d = scan.next_col;
            scan_row_d = scan.next_row;
          end
        end
        CMD_READ: begin
          // a bad address still echoes back
          s1_ok_d    = read_ok;
          s1_paddr_d = read_address_i;
          s1_addr_d  = AW'(read_address_i);
          mem_raddr  = AW'(read_address_i);
          mem_re     = read_ok;
        end
        CMD_RESTART: begin
          if (!win.empty) begin
            s1_ok_d    = 1'b1;
            scan_col_d = win.x0;
            scan_row_d = win.y0;
          end
        end
        default: ;
      endcase
    end
  end

  // saturating update of the fetched entry
  always_comb begin
    updated.red   = sat_add32(rdata_q.red, s1_red_q);
    updated.green = sat_add32(rdata_q.green, s1_green_q);
    updated.blue  = sat_add32(rdata_q.blue, s1_blue_q);
    updated.count = (rdata_q.count == 16'hFFFF) ? rdata_q.count : rdata_q.count + 16'd1;
  end

  // write port: clearing pass or write-back of an accumulate
  always_comb begin
    clearing_d = clearing_q;
    clr_d      = clr_q;
    mem_we     = 1'b0;
    mem_waddr  = s1_addr_q;
    mem_wdata  = updated;
    if (clearing_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_q;
      mem_wdata = '0;
      clr_d     = clr_q + AW'(1);
      if (clr_q == AW'(Depth - 1)) begin
        clearing_d = 1'b0;
      end
    end else if (s1_valid_q && s1_ok_q && s1_cmd_q == CMD_ACCUMULATE) begin
      mem_we = 1'b1;
    end
  end

  // result formation
  always_comb begin
    out_ok_d    = s1_ok_q;
    out_last_d  = s1_last_q;
    out_paddr_d = s1_paddr_q;
    out_pix_d   = '0;
    if (s1_ok_q) begin
      case (s1_cmd_q)
        CMD_ACCUMULATE: out_pix_d = updated;
        CMD_READ:       out_pix_d = rdata_q;
        default:        out_pix_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width    <= CoordW'(256);
      cfg_q.image_height   <= CoordW'(256);
      cfg_q.window_left    <= '0;
      cfg_q.window_top     <= '0;
      cfg_q.window_columns <= CoordW'(256);
      cfg_q.window_rows    <= CoordW'(256);
      scan_col_q           <= '0;
      scan_row_q           <= '0;
      clearing_q           <= 1'b1;
      clr_q                <= '0;
      s1_valid_q           <= 1'b0;
      result_valid_q       <= 1'b0;
    end else begin
      cfg_q          <= cfg_d;
      scan_col_q     <= scan_col_d;
      scan_row_q     <= scan_row_d;
      clearing_q     <= clearing_d;
      clr_q          <= clr_d;
      s1_valid_q     <= s1_valid_d;
      result_valid_q <= s1_valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s1_cmd_q    <= s1_cmd_d;
    s1_ok_q     <= s1_ok_d;
    s1_last_q   <= s1_last_d;
    s1_addr_q   <= s1_addr_d;
    s1_paddr_q  <= s1_paddr_d;
    s1_red_q    <= s1_red_d;
    s1_green_q  <= s1_green_d;
    s1_blue_q   <= s1_blue_d;
    if (s1_valid_q) begin
      out_pix_q   <= out_pix_d;
      out_ok_q    <= out_ok_d;
      out_last_q  <= out_last_d;
      out_paddr_q <= out_paddr_d;
    end
  end

  // pixel memory, one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= store_q[mem_raddr];
    end
  end

  assign result_valid_o  = result_valid_q;
  assign accepted_o      = out_ok_q;
  assign pixel_address_o = out_paddr_q;
  assign red_sum_o       = out_pix_q.red;
  assign green_sum_o     = out_pix_q.green;
  assign blue_sum_o      = out_pix_q.blue;
  assign sample_count_o  = out_pix_q.count;
  assign pass_done_o     = out_last_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |=> result_valid_o)
    else $error("stage one request produced no result");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !s1_valid_q)
    else $error("new request in flight while previous result is shown");

  a_done_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && pass_done_o) |-> accepted_o)
    else $error("pass done on a request that did not act");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clearing_q |=> !clearing_q)
    else $error("clearing pass restarted without reset");

endmodule

@@ sv/swa_scan.sv @@
// window clipping and serpentine scan stepping
`timescale 1ns / 1ps

module swa_scan import swa_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  cfg_t              cfg_i,
  input  logic [CoordW-1:0] scan_col_i,
  input  logic [CoordW-1:0] scan_row_i,
  output win_t              win_o,
  output scan_t             scan_o
);

  localparam logic [12:0] MaxW = 13'(MAX_WIDTH);
  localparam logic [12:0] MaxH = 13'(MAX_HEIGHT);

  logic [CoordW:0]   x1_sum, y1_sum, col_inc, row_inc;
  logic              in_win, odd;
  win_t              win;
  scan_t             scan;

  always_comb begin
    win = '0;
    if (cfg_i.image_width == '0) begin
      win.w = CoordW'(1);
    end else if ({4'd0, cfg_i.image_width} > MaxW) begin
      win.w = CoordW'(MAX_WIDTH);
    end else begin
      win.w = cfg_i.image_width;
    end
    if (cfg_i.image_height == '0) begin
      win.h = CoordW'(1);
    end else if ({4'd0, cfg_i.image_height} > MaxH) begin
      win.h = CoordW'(MAX_HEIGHT);
    end else begin
      win.h = cfg_i.image_height;
    end
    win.x0 = cfg_i.window_left;
    win.y0 = cfg_i.window_top;
    x1_sum = {1'b0, cfg_i.window_left} + {1'b0, cfg_i.window_columns};
    y1_sum = {1'b0, cfg_i.window_top} + {1'b0, cfg_i.window_rows};
    win.x1 = (x1_sum > {1'b0, win.w}) ? win.w : x1_sum[CoordW-1:0];
    win.y1 = (y1_sum > {1'b0, win.h}) ? win.h : y1_sum[CoordW-1:0];
    win.empty = (win.x1 <= win.x0) || (win.y1 <= win.y0);
    win.area = win.w * win.h;
  end

  always_comb begin
    scan = '0;
    // a position left outside the window restarts at its first pixel
    in_win = !(scan_row_i < win.y0 || scan_row_i >= win.y1 ||
               scan_col_i < win.x0 || scan_col_i >= win.x1);
    scan.col = in_win ? scan_col_i : win.x0;
    scan.row = in_win ? scan_row_i : win.y0;
    odd = scan.row[0] ^ win.y0[0];
    col_inc = {1'b0, scan.col} + (CoordW+1)'(1);
    row_inc = {1'b0, scan.row} + (CoordW+1)'(1);
    scan.next_col = scan.col;
    scan.next_row = scan.row;
    if (!odd && col_inc < {1'b0, win.x1}) begin
      scan.next_col = col_inc[CoordW-1:0];
    end else if (odd && scan.col > win.x0) begin
      scan.next_col = scan.col - CoordW'(1);
    end else if (row_inc < {1'b0, win.y1}) begin
      scan.next_row = row_inc[CoordW-1:0];
    end else begin
      scan.last     = 1'b1;
      scan.next_col = win.x0;
      scan.next_row = win.y0;
    end
  end

  assign win_o  = win;
  assign scan_o = scan;

endmodule
